### hdl/rkgm_pkg.sv
package rkgm_pkg;

    typedef logic [2:0] command_t;
    typedef logic [3:0] action_t;
    typedef logic [1:0] cfg_index_t;

    localparam command_t CMD_LEFT    = 3'd0;
    localparam command_t CMD_RIGHT   = 3'd1;
    localparam command_t CMD_PRESS   = 3'd2;
    localparam command_t CMD_RELEASE = 3'd3;
    localparam command_t CMD_TICK    = 3'd4;

    localparam action_t ACT_KLEFT   = 4'd0;
    localparam action_t ACT_KRIGHT  = 4'd1;
    localparam action_t ACT_PUSH    = 4'd2;
    localparam action_t ACT_VOLDOWN = 4'd3;
    localparam action_t ACT_VOLUP   = 4'd4;
    localparam action_t ACT_PREV    = 4'd5;
    localparam action_t ACT_NEXT    = 4'd6;
    localparam action_t ACT_TOGGLE  = 4'd7;
    localparam action_t ACT_PAUSE   = 4'd8;
    localparam action_t ACT_PLAY    = 4'd9;
    localparam action_t ACT_BLEFT   = 4'd10;

    localparam cfg_index_t CFG_RAW_MODE     = 2'd0;
    localparam cfg_index_t CFG_KNOB_ONLY    = 2'd1;
    localparam cfg_index_t CFG_VOLUME_LOCK  = 2'd2;
    localparam cfg_index_t CFG_CLICK_WINDOW = 2'd3;

    localparam logic [15:0] CLICK_WINDOW_RESET = 16'd350;

endpackage

### hdl/rotary_knob_gesture_mapper_unit.sv
// An item is captured in the input register at its transfer and resolved into the output
// register once that register is free to take its result.
// Throughput: one item per cycle while the output is not stalled; an item with two results
// holds the single output register until both of them have been taken.
// Reset (aresetn, synchronous, active low) clears the gesture state, the handshakes and
// the mode registers, and loads the click window length with 350.
module rotary_knob_gesture_mapper_unit #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  rkgm_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]           cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  rkgm_pkg::command_t    s_command,
    input  logic                  s_long_press,

    output logic                  m_valid,
    input  logic                  m_ready,
    output rkgm_pkg::action_t     m_action,
    output logic                  m_pressed,
    output logic                  m_last
);

    localparam logic [32:0] WIN_MAX_WIDE = (33'd1 << WINDOW_BITS) - 33'd1;
    localparam logic [31:0] WIN_MAX      = WIN_MAX_WIDE[31:0];

    // Configuration registers.
    logic        raw_mode_reg;
    logic        knob_only_reg;
    logic        volume_lock_reg;
    logic [15:0] click_window_reg;

    // Input register.
    logic                 in_valid_reg, in_valid_next;
    rkgm_pkg::command_t   in_command_reg;
    logic                 in_long_press_reg;

    // Gesture state.
    logic                   long_state_reg, long_state_next;
    logic                   click_armed_reg, click_armed_next;
    logic [1:0]             left_turns_reg, left_turns_next;
    logic                   win_run_reg, win_run_next;
    logic [WINDOW_BITS-1:0] win_count_reg, win_count_next;

    // Output register; dup marks a second, identical result still to be delivered.
    logic                 m_valid_reg, m_valid_next;
    logic                 m_dup_reg, m_dup_next;
    rkgm_pkg::action_t    m_action_reg;
    logic                 m_pressed_reg;

    logic                   out_free;
    logic                   in_fire;
    logic                   emit;
    logic                   emit_dup;
    rkgm_pkg::action_t      emit_action;
    logic                   emit_pressed;
    logic [31:0]            win_wide;
    logic [31:0]            win_sat;
    logic [WINDOW_BITS-1:0] win_load;
    logic [WINDOW_BITS-1:0] win_dec;

    assign out_free = !m_valid_reg || (m_ready && !m_dup_reg);
    assign in_fire  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid   = m_valid_reg;
    assign m_action  = m_action_reg;
    assign m_pressed = m_pressed_reg;
    assign m_last    = !m_dup_reg;

    // Window start value: zero counts as one, values beyond the counter saturate.
    assign win_wide = {16'd0, click_window_reg};
    assign win_sat  = (win_wide > WIN_MAX) ? WIN_MAX : win_wide;
    assign win_load = (click_window_reg == 16'd0) ? WINDOW_BITS'(1)
                                                  : win_sat[WINDOW_BITS-1:0];
    assign win_dec  = win_count_reg - WINDOW_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_mode_reg     <= 1'b0;
            knob_only_reg    <= 1'b0;
            volume_lock_reg  <= 1'b0;
            click_window_reg <= rkgm_pkg::CLICK_WINDOW_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rkgm_pkg::CFG_RAW_MODE:     raw_mode_reg     <= cfg_wr_data[0];
                rkgm_pkg::CFG_KNOB_ONLY:    knob_only_reg    <= cfg_wr_data[0];
                rkgm_pkg::CFG_VOLUME_LOCK:  volume_lock_reg  <= cfg_wr_data[0];
                rkgm_pkg::CFG_CLICK_WINDOW: click_window_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        long_state_next  = long_state_reg;
        click_armed_next = click_armed_reg;
        left_turns_next  = left_turns_reg;
        win_run_next     = win_run_reg;
        win_count_next   = win_count_reg;
        emit             = 1'b0;
        emit_dup         = 1'b0;
        emit_action      = rkgm_pkg::ACT_KLEFT;
        emit_pressed     = 1'b1;

        if (in_command_reg == rkgm_pkg::CMD_TICK) begin
            if (win_run_reg) begin
                win_count_next = win_dec;
                if (win_dec == '0) begin
                    win_run_next = 1'b0;
                    if (click_armed_reg) begin
                        emit             = 1'b1;
                        emit_action      = rkgm_pkg::ACT_PUSH;
                        click_armed_next = 1'b0;
                    end else if (left_turns_reg != 2'd0) begin
                        emit            = (left_turns_reg == 2'd1);
                        emit_action     = rkgm_pkg::ACT_KLEFT;
                        left_turns_next = 2'd0;
                    end
                end
            end
        end else if (in_command_reg > rkgm_pkg::CMD_TICK) begin
            // Unknown commands are dropped without effect.
        end else if (raw_mode_reg) begin
            emit = 1'b1;
            case (in_command_reg)
                rkgm_pkg::CMD_LEFT:  emit_action = rkgm_pkg::ACT_KLEFT;
                rkgm_pkg::CMD_RIGHT: emit_action = rkgm_pkg::ACT_KRIGHT;
                rkgm_pkg::CMD_PRESS: emit_action = rkgm_pkg::ACT_PUSH;
                default: begin
                    emit_action  = rkgm_pkg::ACT_PUSH;
                    emit_pressed = 1'b0;
                end
            endcase
        end else if (knob_only_reg) begin
            case (in_command_reg)
                rkgm_pkg::CMD_LEFT: begin
                    // One earlier left turn gives two knob-left results, two give one.
                    emit           = (left_turns_reg != 2'd0);
                    emit_dup       = (left_turns_reg == 2'd1);
                    emit_action    = rkgm_pkg::ACT_KLEFT;
                    win_run_next   = 1'b1;
                    win_count_next = win_load;
                    if (left_turns_reg < 2'd2) begin
                        left_turns_next = left_turns_reg + 2'd1;
                    end
                end
                rkgm_pkg::CMD_RIGHT: begin
                    emit = 1'b1;
                    if (left_turns_reg == 2'd1) begin
                        emit_action     = rkgm_pkg::ACT_PAUSE;
                        left_turns_next = 2'd0;
                        win_run_next    = 1'b0;
                        win_count_next  = '0;
                    end else begin
                        emit_action = rkgm_pkg::ACT_KRIGHT;
                    end
                end
                rkgm_pkg::CMD_PRESS: begin
                    if (in_long_press_reg) begin
                        emit        = 1'b1;
                        emit_action = rkgm_pkg::ACT_PLAY;
                    end else if (click_armed_reg) begin
                        emit           = 1'b1;
                        emit_action    = rkgm_pkg::ACT_BLEFT;
                        win_run_next   = 1'b0;
                        win_count_next = '0;
                    end else begin
                        win_run_next   = 1'b1;
                        win_count_next = win_load;
                    end
                    click_armed_next = !click_armed_reg;
                end
                default: begin
                end
            endcase
        end else begin
            case (in_command_reg)
                rkgm_pkg::CMD_LEFT: begin
                    emit        = 1'b1;
                    emit_action = long_state_reg  ? rkgm_pkg::ACT_PREV :
                                  volume_lock_reg ? rkgm_pkg::ACT_VOLDOWN :
                                                    rkgm_pkg::ACT_KLEFT;
                end
                rkgm_pkg::CMD_RIGHT: begin
                    emit        = 1'b1;
                    emit_action = long_state_reg  ? rkgm_pkg::ACT_NEXT :
                                  volume_lock_reg ? rkgm_pkg::ACT_VOLUP :
                                                    rkgm_pkg::ACT_KRIGHT;
                end
                rkgm_pkg::CMD_PRESS: begin
                    if (in_long_press_reg) begin
                        long_state_next = !long_state_reg;
                    end else begin
                        emit        = 1'b1;
                        emit_action = volume_lock_reg ? rkgm_pkg::ACT_TOGGLE
                                                      : rkgm_pkg::ACT_PUSH;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_dup_next   = m_dup_reg;
        if (m_valid_reg && m_ready) begin
            if (m_dup_reg) begin
                m_dup_next = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
        if (in_fire && emit) begin
            m_valid_next = 1'b1;
            m_dup_next   = emit_dup;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_dup_reg       <= 1'b0;
            long_state_reg  <= 1'b0;
            click_armed_reg <= 1'b0;
            left_turns_reg  <= 2'd0;
            win_run_reg     <= 1'b0;
            win_count_reg   <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            m_dup_reg    <= m_dup_next;
            if (in_fire) begin
                long_state_reg  <= long_state_next;
                click_armed_reg <= click_armed_next;
                left_turns_reg  <= left_turns_next;
                win_run_reg     <= win_run_next;
                win_count_reg   <= win_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_command_reg    <= s_command;
            in_long_press_reg <= s_long_press;
        end
        if (in_fire && emit) begin
            m_action_reg  <= emit_action;
            m_pressed_reg <= emit_pressed;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_dup_reg |-> m_valid_reg)
        else $error("second result pending without a valid output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        left_turns_reg != 2'd3)
        else $error("left turn count went past its saturation value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !win_run_reg |-> (win_count_reg == '0))
        else $error("click window count left non-zero while stopped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_last))
        else $error("first of two results not followed by the final one");
`endif

endmodule
